// File: hw/rtl/tmbp_pkg.sv
// Shared constants, outcome codes and sequencer states of the ternary multiply propagator.
package tmbp_pkg;

    localparam int FIELD_W    = 32;
    localparam int TMBP_WIDTH = 32;
    localparam int S_TDATA_W  = 6 * FIELD_W;
    localparam int M_TDATA_W  = 200;

    typedef enum logic [1:0] {
        OC_SAME = 2'd0,
        OC_CHG  = 2'd1,
        OC_BAD  = 2'd2
    } outcome_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TP_SCAN,
        ST_TP_A,
        ST_TP_B,
        ST_TP_LZ,
        ST_TP_O,
        ST_BUILD,
        ST_SNAP,
        ST_TIGHT,
        ST_TIGHT_END,
        ST_FIXP,
        ST_FCNT,
        ST_FAPPLY,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/ternary_multiply_bit_propagator_unit.sv
// Top level of the ternary multiply propagator: sequencer, bit vectors and column count stores.
//
// The s_ channel takes one item of three ternary vectors (mask and values of x, y and the
// product). The m_ channel returns one item with the tightened vectors and a 2-bit outcome:
// unchanged, changed or conflict. The block works on one item at a time and holds s_tready
// low from acceptance until the result has been placed in the output register.
// All work runs through narrow adders and comparators under a sequencer, one bit position or
// one partial-product pair per cycle. The trailing-zero passes search pairs in an inner loop,
// the column count build visits every partial-product pair, every round of the column sum
// settling scans all columns and repeats until nothing moves, and the operand fixing of exact
// columns scans each such column once to count and may scan it again to set bits.
// The result waits in the output register while m_tready is low; the sequencer meanwhile may
// accept a new item, but holds that item in its final state until the waiting result is taken.
// A synchronous active-low reset returns the sequencer to idle and drops m_tvalid; no clearing
// pass is needed since every store is written before it is read.
module ternary_multiply_bit_propagator_unit
    import tmbp_pkg::*;
#(
    parameter int WIDTH = TMBP_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // x_known, x_bits, y_known, y_bits, prod_known, prod_bits (32 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // new_x_known, new_x_bits, new_y_known, new_y_bits, new_prod_known, new_prod_bits,
    // outcome (2 bits), zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(WIDTH + 1);
    localparam int XW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CW = $clog2(WIDTH + 1) + 4;
    localparam int EW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
    localparam logic [IW-1:0] LAST  = IW'(WIDTH - 1);
    localparam logic [IW-1:0] WFULL = IW'(WIDTH);
    localparam logic [IW:0]   WEXT  = (IW+1)'(WIDTH);
    localparam logic [XW-1:0] LIDX  = XW'(WIDTH - 1);
    localparam logic signed [CW-1:0] C_ONE  = CW'(1);
    localparam logic signed [CW-1:0] C_ZERO = CW'(0);

    function automatic logic bit_at(input logic [WIDTH-1:0] v, input logic [IW:0] idx);
        logic r;
        r = 1'b0;
        if (idx < WEXT) r = v[idx[XW-1:0]];
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] one_hot(input logic [IW-1:0] idx);
        logic [WIDTH-1:0] r;
        r = '0;
        if (idx < WFULL) r[idx[XW-1:0]] = 1'b1;
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] widen(input logic [FIELD_W-1:0] f);
        logic [WIDTH-1:0] r;
        r = '0;
        r[EW-1:0] = f[EW-1:0];
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] narrow(input logic [WIDTH-1:0] v);
        logic [FIELD_W-1:0] r;
        r = '0;
        r[EW-1:0] = v[EW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] half_tz(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = v + $signed({{(CW-1){1'b0}}, v[CW-1]});
        return t >>> 1;
    endfunction

    state_t state_reg, state_next;
    logic [WIDTH-1:0] xk_reg, xk_next, xv_reg, xv_next;
    logic [WIDTH-1:0] yk_reg, yk_next, yv_reg, yv_next;
    logic [WIDTH-1:0] ok_reg, ok_next, ov_reg, ov_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] bmin_reg, bmin_next, bmax_reg, bmax_next, omax_reg, omax_next;
    logic [IW-1:0] lzx_reg, lzx_next, lzy_reg, lzy_next;
    logic runb_reg, runb_next, runx_reg, runx_next, runy_reg, runy_next;
    logic swap_reg, swap_next, final_reg, final_next, lchg_reg, lchg_next;
    logic mode_reg, mode_next;
    outcome_t rt_reg, rt_next, res_reg, res_next, oc_reg, oc_next;
    logic signed [CW-1:0] acc_lo_reg, acc_lo_next, acc_hi_reg, acc_hi_next;
    logic signed [CW-1:0] p_lo_reg, p_lo_next, p_hi_reg, p_hi_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [CW-1:0] clo_mem [WIDTH];
    logic signed [CW-1:0] chi_mem [WIDTH];
    logic signed [CW-1:0] slo_mem [WIDTH];
    logic signed [CW-1:0] shi_mem [WIDTH];
    logic signed [CW-1:0] rd_clo_reg, rd_chi_reg, rd_slo_reg, rd_shi_reg;
    logic cw_en, sw_en;
    logic [XW-1:0] cw_idx, sw_idx, rd_idx;
    logic signed [CW-1:0] cw_lo, cw_hi, sw_lo, sw_hi;

    logic [WIDTH-1:0] a_k, a_v, b_k, b_v;
    logic [IW:0] i_e, j_e, ij, cmj_e, nlz;
    logic [IW-1:0] cmj, lim;
    logic za_i, oa_i, zb_i, ob_i, zb_j, zo_ij, fo_i, vo_i, zx_i, zy_i;
    logic fx_c, vx_c, fy_j, vy_j, pair_nz, pair_one;
    logic tpa_end, tpb_fix, tpb_stop, tpo_done, tpo_bad;
    logic signed [CW-1:0] c_s, cp1, bld_clo, bld_chi, bld_slo, bld_shi, cl_b, chh_b;
    logic signed [CW-1:0] sn_lo_in, sn_hi_in, sn_lo, sn_hi;
    logic sn_chg, sn_bad, empty;
    logic signed [CW-1:0] cl, chh, t1, t2, slo1, shi1, d1, d2, plo1, phi1, t3, t4, clo1, chi1;
    logic tchg1;
    logic signed [CW-1:0] clo0, chi0, slo0, shi0;
    logic tchg0;
    logic exact_c, exact_s, fixp_bad;
    logic signed [CW-1:0] ones_f;
    logic mode1, mode0, mode_any;
    logic sety, setx;
    outcome_t res_after;
    logic last_i, last_j, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign a_k = swap_reg ? yk_reg : xk_reg;
    assign a_v = swap_reg ? yv_reg : xv_reg;
    assign b_k = swap_reg ? xk_reg : yk_reg;
    assign b_v = swap_reg ? xv_reg : yv_reg;

    assign i_e   = {1'b0, i_reg};
    assign j_e   = {1'b0, j_reg};
    assign ij    = i_e + j_e;
    assign cmj   = i_reg - j_reg;
    assign cmj_e = {1'b0, cmj};
    assign lim   = (bmax_reg < omax_reg) ? bmax_reg : omax_reg;
    assign nlz   = {1'b0, lzx_reg} + {1'b0, lzy_reg};
    assign last_i = (i_reg == LAST);
    assign last_j = (j_reg == i_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign za_i  = bit_at(a_k, i_e) & ~bit_at(a_v, i_e);
    assign oa_i  = bit_at(a_k, i_e) & bit_at(a_v, i_e);
    assign zb_i  = bit_at(b_k, i_e) & ~bit_at(b_v, i_e);
    assign ob_i  = bit_at(b_k, i_e) & bit_at(b_v, i_e);
    assign zb_j  = bit_at(b_k, j_e) & ~bit_at(b_v, j_e);
    assign zo_ij = bit_at(ok_reg, ij) & ~bit_at(ov_reg, ij);
    assign fo_i  = bit_at(ok_reg, i_e);
    assign vo_i  = bit_at(ov_reg, i_e);
    assign zx_i  = bit_at(xk_reg, i_e) & ~bit_at(xv_reg, i_e);
    assign zy_i  = bit_at(yk_reg, i_e) & ~bit_at(yv_reg, i_e);

    assign fx_c = bit_at(xk_reg, cmj_e);
    assign vx_c = bit_at(xv_reg, cmj_e);
    assign fy_j = bit_at(yk_reg, j_e);
    assign vy_j = bit_at(yv_reg, j_e);
    assign pair_nz  = !(fx_c && !vx_c) && !(fy_j && !vy_j);
    assign pair_one = fx_c && vx_c && fy_j && vy_j;

    assign tpa_end  = (i_reg == WFULL) || oa_i;
    assign tpb_fix  = j_reg > lim;
    assign tpb_stop = (ij >= WEXT) || (!zb_j && !zo_ij);
    assign tpo_done = (i_e >= nlz) || (i_reg == WFULL);
    assign tpo_bad  = fo_i && vo_i;

    assign c_s     = $signed({{(CW-IW){1'b0}}, i_reg});
    assign cp1     = c_s + C_ONE;
    assign bld_clo = acc_lo_reg + (pair_one ? C_ONE : C_ZERO);
    assign bld_chi = acc_hi_reg + (pair_nz ? C_ONE : C_ZERO);
    assign cl_b    = (i_reg == '0) ? C_ZERO : half_tz(p_lo_reg);
    assign chh_b   = (i_reg == '0) ? C_ZERO : half_tz(p_hi_reg);
    assign bld_slo = bld_clo + cl_b;
    assign bld_shi = bld_chi + chh_b;

    assign sn_lo_in = (state_reg == ST_BUILD) ? bld_slo : rd_slo_reg;
    assign sn_hi_in = (state_reg == ST_BUILD) ? bld_shi : rd_shi_reg;
    assign sn_lo  = (fo_i && (sn_lo_in[0] != vo_i)) ? sn_lo_in + C_ONE : sn_lo_in;
    assign sn_hi  = (fo_i && (sn_hi_in[0] != vo_i)) ? sn_hi_in - C_ONE : sn_hi_in;
    assign sn_chg = fo_i && ((sn_lo_in[0] != vo_i) || (sn_hi_in[0] != vo_i));
    assign sn_bad = fo_i && ((sn_hi < sn_lo) || sn_lo[CW-1]);
    assign empty  = (rd_slo_reg > rd_shi_reg) || (rd_clo_reg > rd_chi_reg);

    assign cl   = half_tz(p_lo_reg);
    assign chh  = half_tz(p_hi_reg);
    assign t1   = rd_clo_reg + cl;
    assign slo1 = (rd_slo_reg < t1) ? t1 : rd_slo_reg;
    assign t2   = rd_chi_reg + chh;
    assign shi1 = (rd_shi_reg > t2) ? t2 : rd_shi_reg;
    assign d1   = slo1 - rd_chi_reg;
    assign plo1 = (d1 > cl) ? d1 + d1 : p_lo_reg;
    assign d2   = shi1 - rd_clo_reg;
    assign phi1 = (d2 < chh) ? d2 + d2 + C_ONE : p_hi_reg;
    assign t3   = slo1 - chh;
    assign clo1 = (t3 > rd_clo_reg) ? t3 : rd_clo_reg;
    assign t4   = shi1 - cl;
    assign chi1 = (t4 < rd_chi_reg) ? t4 : rd_chi_reg;
    assign tchg1 = (rd_slo_reg < t1) || (rd_shi_reg > t2) || (d1 > cl) || (d2 < chh)
                || (t3 > rd_clo_reg) || (t4 < rd_chi_reg);

    assign clo0 = (rd_slo_reg > rd_clo_reg) ? rd_slo_reg : rd_clo_reg;
    assign slo0 = (rd_slo_reg < rd_clo_reg) ? rd_clo_reg : rd_slo_reg;
    assign chi0 = (rd_shi_reg < rd_chi_reg) ? rd_shi_reg : rd_chi_reg;
    assign shi0 = (rd_shi_reg > rd_chi_reg) ? rd_chi_reg : rd_shi_reg;
    assign tchg0 = (rd_slo_reg != rd_clo_reg) || (rd_shi_reg != rd_chi_reg);

    assign exact_s  = (rd_slo_reg == rd_shi_reg);
    assign fixp_bad = exact_s && fo_i && (vo_i != rd_shi_reg[0]);
    assign exact_c  = (rd_clo_reg == rd_chi_reg);
    assign ones_f   = acc_lo_reg + (pair_one ? C_ONE : C_ZERO);
    assign mode1    = (rd_chi_reg == cp1) && (ones_f < cp1);
    assign mode0    = (rd_chi_reg == ones_f) && (ones_f < cp1);
    assign mode_any = mode1 || mode0;

    assign sety = mode_reg ? (!fy_j && !(fx_c && !vx_c)) : (!fy_j && fx_c && vx_c);
    assign setx = mode_reg ? (!fx_c && !(fy_j && !vy_j)) : (!fx_c && fy_j && vy_j);
    assign res_after = (sety || setx) ? OC_CHG : res_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_TP_SCAN;
            end
            ST_TP_SCAN: begin
                if (last_i) state_next = ST_TP_A;
            end
            ST_TP_A: begin
                if (tpa_end) state_next = swap_reg ? ST_TP_LZ : ST_TP_SCAN;
                else if (!za_i) state_next = ST_TP_B;
            end
            ST_TP_B: begin
                if (tpb_fix) state_next = ST_TP_A;
                else if (tpb_stop) state_next = swap_reg ? ST_TP_LZ : ST_TP_SCAN;
            end
            ST_TP_LZ: begin
                if (last_i) state_next = ST_TP_O;
            end
            ST_TP_O: begin
                if (tpo_done) state_next = final_reg ? ST_DONE : ST_BUILD;
                else if (tpo_bad) state_next = ST_DONE;
            end
            ST_BUILD: begin
                if (last_j && last_i) state_next = ST_SNAP;
            end
            ST_SNAP: begin
                if (sn_bad || empty) state_next = ST_DONE;
                else if (last_i) state_next = ST_TIGHT;
            end
            ST_TIGHT: begin
                if (last_i) state_next = ST_TIGHT_END;
            end
            ST_TIGHT_END: begin
                state_next = lchg_reg ? ST_SNAP : ST_FIXP;
            end
            ST_FIXP: begin
                if (fixp_bad) state_next = ST_DONE;
                else if (last_i) state_next = ST_FCNT;
            end
            ST_FCNT: begin
                if (exact_c && last_j && mode_any) state_next = ST_FAPPLY;
                else if ((!exact_c || last_j) && last_i)
                    state_next = (res_reg == OC_CHG) ? ST_TP_SCAN : ST_DONE;
            end
            ST_FAPPLY: begin
                if (last_j) begin
                    if (last_i) state_next = (res_after == OC_CHG) ? ST_TP_SCAN : ST_DONE;
                    else state_next = ST_FCNT;
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        xk_next = xk_reg;  xv_next = xv_reg;
        yk_next = yk_reg;  yv_next = yv_reg;
        ok_next = ok_reg;  ov_next = ov_reg;
        i_next = i_reg;  j_next = j_reg;
        bmin_next = bmin_reg;  bmax_next = bmax_reg;  omax_next = omax_reg;
        lzx_next = lzx_reg;  lzy_next = lzy_reg;
        runb_next = runb_reg;  runx_next = runx_reg;  runy_next = runy_reg;
        swap_next = swap_reg;  final_next = final_reg;  lchg_next = lchg_reg;
        mode_next = mode_reg;
        rt_next = rt_reg;  res_next = res_reg;  oc_next = oc_reg;
        acc_lo_next = acc_lo_reg;  acc_hi_next = acc_hi_reg;
        p_lo_next = p_lo_reg;  p_hi_next = p_hi_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        cw_en = 1'b0;  cw_idx = i_reg[XW-1:0];  cw_lo = C_ZERO;  cw_hi = C_ZERO;
        sw_en = 1'b0;  sw_idx = i_reg[XW-1:0];  sw_lo = C_ZERO;  sw_hi = C_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    xk_next = widen(s_tdata[FIELD_W-1:0]);
                    xv_next = widen(s_tdata[2*FIELD_W-1:FIELD_W]) & widen(s_tdata[FIELD_W-1:0]);
                    yk_next = widen(s_tdata[3*FIELD_W-1:2*FIELD_W]);
                    yv_next = widen(s_tdata[4*FIELD_W-1:3*FIELD_W])
                            & widen(s_tdata[3*FIELD_W-1:2*FIELD_W]);
                    ok_next = widen(s_tdata[5*FIELD_W-1:4*FIELD_W]);
                    ov_next = widen(s_tdata[6*FIELD_W-1:5*FIELD_W])
                            & widen(s_tdata[5*FIELD_W-1:4*FIELD_W]);
                    swap_next = 1'b0;  final_next = 1'b0;
                    rt_next = OC_SAME;  res_next = OC_SAME;
                    i_next = '0;  bmin_next = '0;  bmax_next = WFULL;  omax_next = WFULL;
                    runb_next = 1'b1;
                end
            end
            ST_TP_SCAN: begin
                if (runb_reg && zb_i) bmin_next = i_reg + IW'(1);
                else runb_next = 1'b0;
                if (bmax_reg == WFULL && ob_i) bmax_next = i_reg;
                if (omax_reg == WFULL && fo_i && vo_i) omax_next = i_reg;
                i_next = last_i ? '0 : i_reg + IW'(1);
            end
            ST_TP_A, ST_TP_B: begin
                if (state_reg == ST_TP_A && !tpa_end && za_i) begin
                    i_next = i_reg + IW'(1);
                end else if (state_reg == ST_TP_A && !tpa_end) begin
                    j_next = bmin_reg;
                end else if (state_reg == ST_TP_B && tpb_fix) begin
                    if (swap_reg) yk_next = yk_reg | one_hot(i_reg);
                    else xk_next = xk_reg | one_hot(i_reg);
                    rt_next = OC_CHG;
                    i_next = i_reg + IW'(1);
                end else if (state_reg == ST_TP_B && !tpb_stop) begin
                    j_next = j_reg + IW'(1);
                end else if (!swap_reg) begin
                    swap_next = 1'b1;
                    i_next = '0;  bmin_next = '0;  bmax_next = WFULL;  omax_next = WFULL;
                    runb_next = 1'b1;
                end else begin
                    i_next = '0;  lzx_next = '0;  lzy_next = '0;
                    runx_next = 1'b1;  runy_next = 1'b1;
                end
            end
            ST_TP_LZ: begin
                if (runx_reg && zx_i) lzx_next = i_reg + IW'(1);
                else runx_next = 1'b0;
                if (runy_reg && zy_i) lzy_next = i_reg + IW'(1);
                else runy_next = 1'b0;
                i_next = last_i ? '0 : i_reg + IW'(1);
            end
            ST_TP_O: begin
                if (tpo_done) begin
                    if (final_reg) begin
                        oc_next = res_reg;
                    end else begin
                        res_next = rt_reg;
                        i_next = '0;  j_next = '0;
                        acc_lo_next = C_ZERO;  acc_hi_next = C_ZERO;
                    end
                end else if (tpo_bad) begin
                    oc_next = OC_BAD;
                end else begin
                    if (!fo_i) begin
                        ok_next = ok_reg | one_hot(i_reg);
                        rt_next = OC_CHG;
                    end
                    i_next = i_reg + IW'(1);
                end
            end
            ST_BUILD: begin
                if (last_j) begin
                    cw_en = 1'b1;  cw_lo = bld_clo;  cw_hi = bld_chi;
                    sw_en = 1'b1;  sw_lo = sn_lo;  sw_hi = sn_hi;
                    p_lo_next = sn_lo;  p_hi_next = sn_hi;
                    acc_lo_next = C_ZERO;  acc_hi_next = C_ZERO;
                    j_next = '0;
                    lchg_next = 1'b0;
                    i_next = last_i ? '0 : i_reg + IW'(1);
                end else begin
                    acc_lo_next = bld_clo;  acc_hi_next = bld_chi;
                    j_next = j_reg + IW'(1);
                end
            end
            ST_SNAP: begin
                if (sn_bad || empty) begin
                    oc_next = OC_BAD;
                end else begin
                    sw_en = 1'b1;  sw_lo = sn_lo;  sw_hi = sn_hi;
                    if (sn_chg) lchg_next = 1'b1;
                    i_next = last_i ? '0 : i_reg + IW'(1);
                end
            end
            ST_TIGHT: begin
                cw_en = 1'b1;
                if (i_reg == '0) begin
                    cw_lo = clo0;  cw_hi = chi0;
                    p_lo_next = slo0;  p_hi_next = shi0;
                    if (tchg0) lchg_next = 1'b1;
                end else begin
                    cw_lo = clo1;  cw_hi = chi1;
                    sw_en = 1'b1;  sw_idx = i_reg[XW-1:0] - XW'(1);
                    sw_lo = plo1;  sw_hi = phi1;
                    p_lo_next = slo1;  p_hi_next = shi1;
                    if (tchg1) lchg_next = 1'b1;
                end
                i_next = last_i ? '0 : i_reg + IW'(1);
            end
            ST_TIGHT_END: begin
                sw_en = 1'b1;  sw_idx = LIDX;  sw_lo = p_lo_reg;  sw_hi = p_hi_reg;
                lchg_next = 1'b0;
                i_next = '0;
            end
            ST_FIXP: begin
                if (fixp_bad) begin
                    oc_next = OC_BAD;
                end else begin
                    if (exact_s && !fo_i) begin
                        ok_next = ok_reg | one_hot(i_reg);
                        if (rd_shi_reg[0]) ov_next = ov_reg | one_hot(i_reg);
                        res_next = OC_CHG;
                    end
                    i_next = last_i ? '0 : i_reg + IW'(1);
                    j_next = '0;
                    acc_lo_next = C_ZERO;
                end
            end
            ST_FCNT: begin
                if (exact_c && !last_j) begin
                    acc_lo_next = ones_f;
                    j_next = j_reg + IW'(1);
                end else if (exact_c && mode_any) begin
                    mode_next = mode1;
                    j_next = '0;
                end else begin
                    acc_lo_next = C_ZERO;
                    j_next = '0;
                    if (!last_i) begin
                        i_next = i_reg + IW'(1);
                    end else if (res_reg == OC_CHG) begin
                        final_next = 1'b1;  swap_next = 1'b0;  rt_next = OC_SAME;
                        i_next = '0;  bmin_next = '0;  bmax_next = WFULL;  omax_next = WFULL;
                        runb_next = 1'b1;
                    end else begin
                        oc_next = res_reg;
                    end
                end
            end
            ST_FAPPLY: begin
                if (sety) begin
                    yk_next = yk_reg | one_hot(j_reg);
                    if (mode_reg) yv_next = yv_reg | one_hot(j_reg);
                end
                if (setx) begin
                    xk_next = xk_reg | one_hot(cmj);
                    if (mode_reg) xv_next = xv_reg | one_hot(cmj);
                end
                res_next = res_after;
                if (last_j) begin
                    acc_lo_next = C_ZERO;
                    j_next = '0;
                    if (!last_i) begin
                        i_next = i_reg + IW'(1);
                    end else if (res_after == OC_CHG) begin
                        final_next = 1'b1;  swap_next = 1'b0;  rt_next = OC_SAME;
                        i_next = '0;  bmin_next = '0;  bmax_next = WFULL;  omax_next = WFULL;
                        runb_next = 1'b1;
                    end else begin
                        oc_next = res_after;
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {6'b0, 2'(oc_reg), narrow(ov_reg), narrow(ok_reg),
                                    narrow(yv_reg), narrow(yk_reg),
                                    narrow(xv_reg), narrow(xk_reg)};
                end
            end
            default: begin
                oc_next = OC_BAD;
            end
        endcase
    end

    assign rd_idx = (i_next < WFULL) ? i_next[XW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cw_en) begin
            clo_mem[cw_idx] <= cw_lo;
            chi_mem[cw_idx] <= cw_hi;
        end
        if (sw_en) begin
            slo_mem[sw_idx] <= sw_lo;
            shi_mem[sw_idx] <= sw_hi;
        end
        rd_clo_reg <= (cw_en && cw_idx == rd_idx) ? cw_lo : clo_mem[rd_idx];
        rd_chi_reg <= (cw_en && cw_idx == rd_idx) ? cw_hi : chi_mem[rd_idx];
        rd_slo_reg <= (sw_en && sw_idx == rd_idx) ? sw_lo : slo_mem[rd_idx];
        rd_shi_reg <= (sw_en && sw_idx == rd_idx) ? sw_hi : shi_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        xk_reg <= xk_next;  xv_reg <= xv_next;
        yk_reg <= yk_next;  yv_reg <= yv_next;
        ok_reg <= ok_next;  ov_reg <= ov_next;
        i_reg <= i_next;  j_reg <= j_next;
        bmin_reg <= bmin_next;  bmax_reg <= bmax_next;  omax_reg <= omax_next;
        lzx_reg <= lzx_next;  lzy_reg <= lzy_next;
        runb_reg <= runb_next;  runx_reg <= runx_next;  runy_reg <= runy_next;
        swap_reg <= swap_next;  final_reg <= final_next;  lchg_reg <= lchg_next;
        mode_reg <= mode_next;
        rt_reg <= rt_next;  res_reg <= res_next;  oc_reg <= oc_next;
        acc_lo_reg <= acc_lo_next;  acc_hi_reg <= acc_hi_next;
        p_lo_reg <= p_lo_next;  p_hi_reg <= p_hi_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the ternary multiply bit propagator with its own bit-true predictor.
module testbench;
    import tmbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = TMBP_WIDTH;

    typedef struct {
        bit [31:0] k;
        bit [31:0] v;
    } tern_t;

    typedef struct {
        bit [31:0] xk, xv, yk, yv, pk, pv;
        outcome_t  oc;
    } prop_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    prop_result_t pending_results[$];
    int           mismatches = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_cycles = 0;

    int col_lo[W], col_hi[W], sum_lo[W], sum_hi[W];

    always #10 aclk = ~aclk;

    ternary_multiply_bit_propagator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic outcome_t worse(outcome_t a, outcome_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic bit is_fx(tern_t d, int i);
        return i < W && d.k[i];
    endfunction

    function automatic bit is_one(tern_t d, int i);
        return is_fx(d, i) && d.v[i];
    endfunction

    function automatic bit is_zero(tern_t d, int i);
        return is_fx(d, i) && !d.v[i];
    endfunction

    function automatic outcome_t fix_bit(inout tern_t d, input int i, input bit b);
        if (i >= W) return OC_SAME;
        if (d.k[i]) return (d.v[i] == b) ? OC_SAME : OC_BAD;
        d.k[i] = 1'b1;
        d.v[i] = b;
        return OC_CHG;
    endfunction

    function automatic int zero_run(tern_t d);
        int i = 0;
        while (i < W && is_zero(d, i)) i++;
        return i;
    endfunction

    function automatic int first_one(tern_t d);
        int i = 0;
        while (i < W && !is_one(d, i)) i++;
        return i;
    endfunction

    // Clears low unknown bits of a that no possible one of b could pair with.
    function automatic outcome_t trim_low(inout tern_t a, input tern_t b, input tern_t o);
        outcome_t r = OC_SAME;
        int bmin = zero_run(b);
        int bmax = first_one(b);
        int omax = first_one(o);
        int lim = (bmax < omax) ? bmax : omax;
        for (int i = 0; i < W; i++) begin
            if (is_zero(a, i)) continue;
            if (is_one(a, i)) break;
            for (int j = bmin; j <= lim; j++) begin
                if (j + i >= W || (!is_zero(b, j) && !is_zero(o, i + j))) return r;
            end
            r = worse(r, fix_bit(a, i, 1'b0));
            if (r == OC_BAD) return OC_BAD;
        end
        return r;
    endfunction

    function automatic outcome_t low_zero_pass(inout tern_t x, inout tern_t y, inout tern_t o);
        outcome_t r0, r1, r2 = OC_SAME;
        int n;
        r0 = trim_low(x, y, o);
        if (r0 == OC_BAD) return OC_BAD;
        r1 = trim_low(y, x, o);
        if (r1 == OC_BAD) return OC_BAD;
        n = zero_run(x) + zero_run(y);
        if (n > W) n = W;
        for (int i = 0; i < n; i++) begin
            r2 = worse(r2, fix_bit(o, i, 1'b0));
            if (r2 == OC_BAD) return OC_BAD;
        end
        return worse(worse(r0, r1), r2);
    endfunction

    function automatic outcome_t snap_col(tern_t o, int i);
        outcome_t c = OC_SAME;
        if (!is_fx(o, i)) return OC_SAME;
        if (sum_hi[i][0] != o.v[i]) begin
            sum_hi[i]--;
            c = OC_CHG;
        end
        if (sum_lo[i][0] != o.v[i]) begin
            sum_lo[i]++;
            c = OC_CHG;
        end
        if (sum_hi[i] < sum_lo[i] || sum_lo[i] < 0) return OC_BAD;
        return c;
    endfunction

    function automatic bit counts_empty();
        for (int i = 0; i < W; i++)
            if (sum_lo[i] > sum_hi[i] || col_lo[i] > col_hi[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit tighten_counts();
        bit chg = 1'b0;
        int cl, ch, t;
        if (sum_lo[0] > col_lo[0]) begin
            col_lo[0] = sum_lo[0]; chg = 1'b1;
        end else if (sum_lo[0] < col_lo[0]) begin
            sum_lo[0] = col_lo[0]; chg = 1'b1;
        end
        if (sum_hi[0] < col_hi[0]) begin
            col_hi[0] = sum_hi[0]; chg = 1'b1;
        end else if (sum_hi[0] > col_hi[0]) begin
            sum_hi[0] = col_hi[0]; chg = 1'b1;
        end
        for (int i = 1; i < W; i++) begin
            cl = sum_lo[i-1] / 2;
            ch = sum_hi[i-1] / 2;
            if (sum_lo[i] < col_lo[i] + cl) begin
                sum_lo[i] = col_lo[i] + cl; chg = 1'b1;
            end
            if (sum_hi[i] > col_hi[i] + ch) begin
                sum_hi[i] = col_hi[i] + ch; chg = 1'b1;
            end
            if (sum_lo[i] - col_hi[i] > cl) begin
                sum_lo[i-1] = (sum_lo[i] - col_hi[i]) * 2; chg = 1'b1;
            end
            if (sum_hi[i] - col_lo[i] < ch) begin
                sum_hi[i-1] = (sum_hi[i] - col_lo[i]) * 2 + 1; chg = 1'b1;
            end
            t = sum_lo[i] - ch;
            if (t > col_lo[i]) begin
                col_lo[i] = t; chg = 1'b1;
            end
            t = sum_hi[i] - cl;
            if (t < col_hi[i]) begin
                col_hi[i] = t; chg = 1'b1;
            end
        end
        return chg;
    endfunction

    function automatic outcome_t settle_counts(tern_t o);
        bit again = 1'b1;
        outcome_t s;
        while (again) begin
            s = OC_SAME;
            if (counts_empty()) return OC_BAD;
            again = 1'b0;
            for (int i = 0; i < W; i++) begin
                s = worse(s, snap_col(o, i));
                if (s == OC_BAD) return OC_BAD;
            end
            if (s == OC_CHG) again = 1'b1;
            if (tighten_counts()) again = 1'b1;
        end
        return counts_empty() ? OC_BAD : OC_SAME;
    endfunction

    function automatic void build_counts(tern_t x, tern_t y, tern_t o);
        outcome_t dummy;
        for (int i = 0; i < W; i++) begin
            col_lo[i] = 0;
            col_hi[i] = i + 1;
        end
        for (int i = 0; i < W; i++) begin
            if (is_zero(y, i))
                for (int j = i; j < W; j++) col_hi[j]--;
            if (is_zero(x, i))
                for (int j = i; j < W; j++)
                    if (!is_zero(y, j - i)) col_hi[j]--;
            if (is_one(x, i))
                for (int j = 0; j < W - i; j++)
                    if (is_one(y, j)) col_lo[i+j]++;
        end
        sum_lo[0] = col_lo[0];
        sum_hi[0] = col_hi[0];
        dummy = snap_col(o, 0);
        for (int i = 1; i < W; i++) begin
            sum_hi[i] = col_hi[i] + sum_hi[i-1] / 2;
            sum_lo[i] = col_lo[i] + sum_lo[i-1] / 2;
            dummy = snap_col(o, i);
        end
    endfunction

    function automatic outcome_t fix_column(inout tern_t x, inout tern_t y, input int c,
                                            input int want);
        int ones = 0, half = 0, none = 0, xi;
        bit a, b;
        outcome_t r = OC_SAME;
        for (int i = 0; i <= c; i++) begin
            a = is_one(x, c - i);
            b = is_one(y, i);
            if (a && b) ones++;
            else if (a || b) half++;
            else none++;
        end
        if (want == ones + half + none && half + none > 0) begin
            for (int i = 0; i <= c; i++) begin
                xi = c - i;
                if (!is_fx(y, i) && !is_zero(x, xi)) begin
                    r = worse(r, fix_bit(y, i, 1'b1));
                    if (r == OC_BAD) return r;
                end
                if (!is_fx(x, xi) && !is_zero(y, i)) begin
                    r = worse(r, fix_bit(x, xi, 1'b1));
                    if (r == OC_BAD) return r;
                end
            end
            return r;
        end
        if (want == ones && (none > 0 || half > 0)) begin
            for (int i = 0; i <= c; i++) begin
                xi = c - i;
                if (!is_fx(y, i) && is_one(x, xi)) begin
                    r = worse(r, fix_bit(y, i, 1'b0));
                    if (r == OC_BAD) return r;
                end
                if (!is_fx(x, xi) && is_one(y, i)) begin
                    r = worse(r, fix_bit(x, xi, 1'b0));
                    if (r == OC_BAD) return r;
                end
            end
        end
        return r;
    endfunction

    function automatic outcome_t tighten_all(inout tern_t x, inout tern_t y, inout tern_t o);
        outcome_t res, r;
        res = low_zero_pass(x, y, o);
        if (res == OC_BAD) return OC_BAD;
        build_counts(x, y, o);
        if (settle_counts(o) == OC_BAD) return OC_BAD;
        for (int c = 0; c < W; c++) begin
            if (sum_lo[c] == sum_hi[c]) begin
                res = worse(res, fix_bit(o, c, sum_hi[c][0]));
                if (res == OC_BAD) return OC_BAD;
            end
        end
        for (int c = 0; c < W; c++) begin
            if (col_lo[c] == col_hi[c]) begin
                r = fix_column(x, y, c, col_hi[c]);
                if (r == OC_BAD) return OC_BAD;
                res = worse(res, r);
            end
        end
        if (res == OC_CHG)
            if (low_zero_pass(x, y, o) == OC_BAD) return OC_BAD;
        return res;
    endfunction

    function automatic prop_result_t propagate_mul(logic [S_TDATA_W-1:0] d);
        tern_t x, y, o;
        prop_result_t e;
        x.k = d[31:0];    x.v = d[63:32] & x.k;
        y.k = d[95:64];   y.v = d[127:96] & y.k;
        o.k = d[159:128]; o.v = d[191:160] & o.k;
        e.oc = tighten_all(x, y, o);
        e.xk = x.k; e.xv = x.v;
        e.yk = y.k; e.yv = y.v;
        e.pk = o.k; e.pv = o.v;
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch in %s: got %h, predicted %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(posedge aclk) begin
        prop_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("[%0t] result item with no prediction waiting", $realtime);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.xk) report_mismatch("new_x_known", m_tdata[31:0], e.xk);
                if (m_tdata[63:32] !== e.xv) report_mismatch("new_x_bits", m_tdata[63:32], e.xv);
                if (m_tdata[95:64] !== e.yk) report_mismatch("new_y_known", m_tdata[95:64], e.yk);
                if (m_tdata[127:96] !== e.yv) report_mismatch("new_y_bits", m_tdata[127:96], e.yv);
                if (m_tdata[159:128] !== e.pk)
                    report_mismatch("new_prod_known", m_tdata[159:128], e.pk);
                if (m_tdata[191:160] !== e.pv)
                    report_mismatch("new_prod_bits", m_tdata[191:160], e.pv);
                if (m_tdata[193:192] !== e.oc)
                    report_mismatch("outcome", 32'(m_tdata[193:192]), 32'(e.oc));
            end
        end
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(logic [31:0] xk, xv, yk, yv, pk, pv);
        logic [S_TDATA_W-1:0] d;
        d = {pv, pk, yv, yk, xv, xk};
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(propagate_mul(d));
    endtask

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(5))
            0: return 32'hffff_ffff;
            1: return 32'h0;
            2: return $urandom() & $urandom();
            3: return $urandom() | $urandom();
            default: return $urandom();
        endcase
    endfunction

    // Mostly consistent operands and product with random fixed masks; some items get
    // flipped fixed bits so that conflicts show up.
    task automatic send_random_item();
        logic [31:0] x, y, p, xk, yk, pk;
        x = $urandom();
        y = $urandom();
        if ($urandom_range(2) == 0) x = x << $urandom_range(31);
        if ($urandom_range(2) == 0) y = y << $urandom_range(31);
        if ($urandom_range(4) == 0) x = $urandom_range(15);
        p = x * y;
        xk = rand_mask();
        yk = rand_mask();
        pk = rand_mask();
        if ($urandom_range(4) == 0) p = p ^ (32'h1 << $urandom_range(31));
        if ($urandom_range(9) == 0) x = x ^ (32'h1 << $urandom_range(31));
        if ($urandom_range(7) == 0) p = $urandom();
        send_item(xk, (x & xk) | ($urandom() & ~xk), yk, (y & yk) | ($urandom() & ~yk),
                  pk, (p & pk) | ($urandom() & ~pk));
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_item(0, 0, 0, 0, 0, 0);
        send_item(0, 32'hffff_ffff, 0, 32'hffff_ffff, 0, 32'hffff_ffff);
        send_item('1, 3, '1, 5, '1, 15);
        send_item('1, 3, '1, 5, '1, 16);
        send_item('1, '1, '1, '1, '1, 1);
        send_item('1, '1, '1, '1, '1, 0);
        send_item('1, 0, 0, 0, 0, 0);
        send_item(32'h0000_00ff, 32'h0000_0010, 0, 0, 0, 0);
        send_item(32'h0000_000f, 32'h0000_0000, 32'h0000_0003, 0, 32'h0000_0001, 1);
        send_item(0, 0, 0, 0, '1, '1);
        send_item(0, 0, 0, 0, '1, 0);
        send_item(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0);
        send_item(32'h1, 32'h1, 32'h1, 32'h1, 0, 0);
        send_item('1, 32'h8000_0000, '1, 32'h8000_0000, '1, 0);
        send_item('1, 32'hffff_ffff, 0, 0, '1, 32'h8000_0000);
        send_item(32'h7, 32'h5, 32'h7, 32'h3, 32'hf, 32'hf);
        send_item(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, '1, 32'hf0f0_f0f0, '1);
        send_item('1, 32'h0001_0000, '1, 32'h0001_0000, 0, 0);
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n) send_random_item();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_cycles = 12000;
        repeat (8) send_random_item();
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 0;
        rx_stall_pct = 30;
        repeat (4) send_random_item();
        s_tvalid <= 1'b0;
        wait_for_drain();
        @(posedge aclk);
        repeat (4) send_random_item();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(28, 0, 0);
        test_random(28, 65, 0);
        test_random(28, 0, 65);
        test_random(28, 24, 24);
        test_backpressure();
        test_drain_pause();
        s_tvalid <= 1'b0;
        rx_stall_pct = 0;
        wait_for_drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
